// ===== sv/rtfh_pkg.sv =====
// ----------------------------------------------------------------------------
// rtfh_pkg
// Shared widths and register addresses for the ray/triangle
// first-hit block.
// ----------------------------------------------------------------------------
package rtfh_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 8;
  localparam int NUM_REGS    = 6;
  localparam int ADDR_WIDTH  = 5;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;

endpackage

// ===== sv/rtfh_if.sv =====
// ----------------------------------------------------------------------------
// rtfh_tri_if / rtfh_hit_if
// Valid/ready channels for triangle requests and hit results.
// ----------------------------------------------------------------------------
interface rtfh_tri_if #(parameter int COORD_WIDTH = rtfh_pkg::COORD_WIDTH);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_a_x;
  logic signed [COORD_WIDTH-1:0] vertex_a_y;
  logic signed [COORD_WIDTH-1:0] vertex_a_z;
  logic signed [COORD_WIDTH-1:0] vertex_b_x;
  logic signed [COORD_WIDTH-1:0] vertex_b_y;
  logic signed [COORD_WIDTH-1:0] vertex_b_z;
  logic signed [COORD_WIDTH-1:0] vertex_c_x;
  logic signed [COORD_WIDTH-1:0] vertex_c_y;
  logic signed [COORD_WIDTH-1:0] vertex_c_z;
  logic                          last_face;
  modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
                  vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                  last_face, input ready);
  modport sink   (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
                  vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                  last_face, output ready);
endinterface

interface rtfh_hit_if #(parameter int COORD_WIDTH = rtfh_pkg::COORD_WIDTH);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] hit_x;
  logic signed [COORD_WIDTH-1:0] hit_y;
  logic signed [COORD_WIDTH-1:0] hit_z;
  modport source (output valid, hit, hit_x, hit_y, hit_z, input ready);
  modport sink   (input valid, hit, hit_x, hit_y, hit_z, output ready);
endinterface

// ===== sv/rtfh_div.sv =====
// ----------------------------------------------------------------------------
// rtfh_div
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module rtfh_div #(
  parameter int WIDTH = 80
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] num,
  input  logic [WIDTH-1:0] den,
  output logic             done,
  output logic [WIDTH-1:0] quo
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    count;
  logic             busy;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  assign trial = {rem, dvd[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(WIDTH);
        rem   <= '0;
        dvd   <= num;
        dvs   <= den;
        quo   <= '0;
      end else if (busy) begin
        if (!diff[WIDTH]) begin
          rem <= diff[WIDTH-1:0];
        end else begin
          rem <= trial[WIDTH-1:0];
        end
        quo   <= {quo[WIDTH-2:0], ~diff[WIDTH]};
        dvd   <= {dvd[WIDTH-2:0], 1'b0};
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== sv/ray_triangle_first_hit.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_first_hit
// One-sided ray/triangle test over a set of triangles, first hit kept.
// ----------------------------------------------------------------------------
// Usage: write the ray origin and direction over the APB port while idle.
// Send triangles on the tri channel; each is tested in turn by one shared
// multiply-accumulate unit that walks a short microprogram (edge vectors,
// cross and dot products, u/v/w checks). A missed triangle keeps ready low
// until its test is done, so a new triangle is taken only after the last.
// Once a triangle is hit, later ones of the set are skipped without a test.
// The triangle that hits also forms the point: per axis four MAC steps and a
// bit-serial divide. A triangle with last_face set yields one result on the
// hit channel: hit flag and point, or zeros. ready is low while a triangle
// is being worked or a result is waiting; a stalled receiver simply holds
// the block. Reset clears registers, the found flag and the stored point.
// ----------------------------------------------------------------------------
module ray_triangle_first_hit #(
  parameter int COORD_WIDTH = rtfh_pkg::COORD_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rtfh_pkg::ADDR_WIDTH-1:0]       paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  rtfh_tri_if.sink                              tri_in,
  rtfh_hit_if.source                            hit_out
);
  // Widths: differences CW+1, cross products up to 2CW+3, dots and the point
  // numerator well inside MW. Multiplier operands are DW by YW.
  localparam int DW    = COORD_WIDTH + 1;
  localparam int YW    = 2 * COORD_WIDTH + 4;
  localparam int PW    = DW + YW;
  localparam int MW    = 4 * COORD_WIDTH + 12;
  localparam int SPLIT = YW - 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MAC   = 4'd1;
  localparam logic [3:0] ST_POINT = 4'd2;
  localparam logic [3:0] ST_DIVGO = 4'd3;
  localparam logic [3:0] ST_DIVW  = 4'd4;
  localparam logic [3:0] ST_END   = 4'd5;
  localparam logic [3:0] ST_OUT   = 4'd6;

  logic [3:0] state;

  logic signed [COORD_WIDTH-1:0] cfg [rtfh_pkg::NUM_REGS];
  logic signed [COORD_WIDTH-1:0] va [3];
  logic signed [COORD_WIDTH-1:0] vb [3];
  logic signed [COORD_WIDTH-1:0] vc [3];
  logic                          last;
  logic                          found;
  logic signed [COORD_WIDTH-1:0] pt [3];

  // register file: e, f, B (diffs) and q, p, D, u, v, w (wide)
  logic signed [DW-1:0] e [3];
  logic signed [DW-1:0] f [3];
  logic signed [DW-1:0] bv [3];
  logic signed [MW-1:0] q [3];
  logic signed [MW-1:0] p [3];
  logic signed [MW-1:0] den, uu, vv, ww;

  // shared MAC: acc +/- (x * y), optionally shifted up by SPLIT
  logic [5:0]           step;
  logic [1:0]           pstep;
  logic [1:0]           axis;
  logic signed [MW-1:0] acc;
  logic signed [DW-1:0] opx;
  logic signed [YW-1:0] opy;
  logic                 sub_op;
  logic                 hi_op;
  logic signed [PW-1:0] prod;
  logic signed [MW-1:0] term;
  logic signed [MW-1:0] acc_next;

  // D and w split into low and high parts for the point numerator
  logic signed [YW-1:0] den_lo, den_hi, ww_lo, ww_hi;

  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    case (paddr[rtfh_pkg::ADDR_WIDTH-1:2])
      rtfh_pkg::REG_ORIGIN_X: prdata = 32'(cfg[0]);
      rtfh_pkg::REG_ORIGIN_Y: prdata = 32'(cfg[1]);
      rtfh_pkg::REG_ORIGIN_Z: prdata = 32'(cfg[2]);
      rtfh_pkg::REG_DIR_X:    prdata = 32'(cfg[3]);
      rtfh_pkg::REG_DIR_Y:    prdata = 32'(cfg[4]);
      rtfh_pkg::REG_DIR_Z:    prdata = 32'(cfg[5]);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rtfh_pkg::NUM_REGS; i++) cfg[i] <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[rtfh_pkg::ADDR_WIDTH-1:2] < 3'(rtfh_pkg::NUM_REGS)) begin
        cfg[paddr[rtfh_pkg::ADDR_WIDTH-1:2]] <= pwdata[COORD_WIDTH-1:0];
      end
    end
  end

  assign den_lo = {1'b0, den[SPLIT-1:0]};
  assign den_hi = YW'(den >>> SPLIT);
  assign ww_lo  = {1'b0, ww[SPLIT-1:0]};
  assign ww_hi  = YW'(ww >>> SPLIT);

  // Microprogram. Each step: acc = (first ? 0 : acc) +/- opx*opy; the last
  // step of a group writes the target. In ST_POINT the same unit forms
  // S*D + d*w for one axis in four steps.
  logic       first, store;
  logic [3:0] target;
  localparam logic [3:0] T_NONE = 4'd0, T_Q0 = 4'd1, T_Q1 = 4'd2, T_Q2 = 4'd3,
                         T_D = 4'd4, T_U = 4'd5, T_P0 = 4'd6, T_P1 = 4'd7,
                         T_P2 = 4'd8, T_V = 4'd9, T_W = 4'd10;

  always_comb begin
    opx = '0; opy = '0; sub_op = 1'b0; hi_op = 1'b0; first = 1'b0; store = 1'b0;
    target = T_NONE;
    if (state == ST_POINT) begin
      first = (pstep == 2'd0);
      hi_op = pstep[0];
      opx   = pstep[1] ? DW'(cfg[rtfh_pkg::REG_DIR_X + 3'(axis)]) : DW'(cfg[3'(axis)]);
      case (pstep)
        2'd0:    opy = den_lo;
        2'd1:    opy = den_hi;
        2'd2:    opy = ww_lo;
        default: opy = ww_hi;
      endcase
    end else begin
      case (step)
        // q = e x d
        6'd0:  begin opx = e[1]; opy = YW'(cfg[5]); first = 1'b1; end
        6'd1:  begin opx = e[2]; opy = YW'(cfg[4]); sub_op = 1'b1; store = 1'b1;
                 target = T_Q0; end
        6'd2:  begin opx = e[2]; opy = YW'(cfg[3]); first = 1'b1; end
        6'd3:  begin opx = e[0]; opy = YW'(cfg[5]); sub_op = 1'b1; store = 1'b1;
                 target = T_Q1; end
        6'd4:  begin opx = e[0]; opy = YW'(cfg[4]); first = 1'b1; end
        6'd5:  begin opx = e[1]; opy = YW'(cfg[3]); sub_op = 1'b1; store = 1'b1;
                 target = T_Q2; end
        // D = f.q
        6'd6:  begin opx = f[0]; opy = YW'(q[0]); first = 1'b1; end
        6'd7:  begin opx = f[1]; opy = YW'(q[1]); end
        6'd8:  begin opx = f[2]; opy = YW'(q[2]); store = 1'b1; target = T_D; end
        // u = B.q
        6'd9:  begin opx = bv[0]; opy = YW'(q[0]); first = 1'b1; end
        6'd10: begin opx = bv[1]; opy = YW'(q[1]); end
        6'd11: begin opx = bv[2]; opy = YW'(q[2]); store = 1'b1; target = T_U; end
        // p = f x B
        6'd12: begin opx = f[1]; opy = YW'(bv[2]); first = 1'b1; end
        6'd13: begin opx = f[2]; opy = YW'(bv[1]); sub_op = 1'b1; store = 1'b1;
                 target = T_P0; end
        6'd14: begin opx = f[2]; opy = YW'(bv[0]); first = 1'b1; end
        6'd15: begin opx = f[0]; opy = YW'(bv[2]); sub_op = 1'b1; store = 1'b1;
                 target = T_P1; end
        6'd16: begin opx = f[0]; opy = YW'(bv[1]); first = 1'b1; end
        6'd17: begin opx = f[1]; opy = YW'(bv[0]); sub_op = 1'b1; store = 1'b1;
                 target = T_P2; end
        // v = d.p
        6'd18: begin opx = DW'(cfg[3]); opy = YW'(p[0]); first = 1'b1; end
        6'd19: begin opx = DW'(cfg[4]); opy = YW'(p[1]); end
        6'd20: begin opx = DW'(cfg[5]); opy = YW'(p[2]); store = 1'b1; target = T_V; end
        // w = e.p
        6'd21: begin opx = e[0]; opy = YW'(p[0]); first = 1'b1; end
        6'd22: begin opx = e[1]; opy = YW'(p[1]); end
        6'd23: begin opx = e[2]; opy = YW'(p[2]); store = 1'b1; target = T_W; end
        default: begin end
      endcase
    end
  end

  assign prod     = PW'(opx * opy);
  assign term     = hi_op ? (MW'(prod) <<< SPLIT) : MW'(prod);
  assign acc_next = (first ? MW'(0) : acc) + (sub_op ? -term : term);

  logic                 num_neg;
  logic [MW-1:0]        num_mag;
  logic                 div_start, div_done;
  logic [MW-1:0]        quo;
  logic signed [COORD_WIDTH-1:0] sat_val;
  localparam logic [MW-1:0] LIM = MW'(1) << (COORD_WIDTH - 1);

  rtfh_div #(.WIDTH(MW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_mag),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    if (num_neg) begin
      sat_val = (quo >= LIM) ? COORD_WIDTH'(LIM) : COORD_WIDTH'(-quo);
    end else begin
      sat_val = (quo >= LIM) ? COORD_WIDTH'(LIM - 1'b1) : COORD_WIDTH'(quo);
    end
  end

  logic tri_hit;
  assign tri_hit = (den > 0) && (uu >= 0) && (uu <= den) && (vv >= 0) &&
                   (uu + vv <= den) && (ww >= 0);

  assign tri_in.ready  = (state == ST_IDLE);
  assign hit_out.valid = (state == ST_OUT);
  assign hit_out.hit   = found;
  assign hit_out.hit_x = pt[0];
  assign hit_out.hit_y = pt[1];
  assign hit_out.hit_z = pt[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      found     <= 1'b0;
      step      <= '0;
      axis      <= '0;
      pstep     <= '0;
      div_start <= 1'b0;
      for (int i = 0; i < 3; i++) pt[i] <= '0;
    end else begin
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (tri_in.valid) begin
            va[0] <= tri_in.vertex_a_x; va[1] <= tri_in.vertex_a_y;
            va[2] <= tri_in.vertex_a_z;
            vb[0] <= tri_in.vertex_b_x; vb[1] <= tri_in.vertex_b_y;
            vb[2] <= tri_in.vertex_b_z;
            vc[0] <= tri_in.vertex_c_x; vc[1] <= tri_in.vertex_c_y;
            vc[2] <= tri_in.vertex_c_z;
            last  <= tri_in.last_face;
            step  <= 6'd63;
            state <= found ? ST_END : ST_MAC;
          end
        end
        ST_MAC: begin
          if (step == 6'd63) begin
            // form the difference vectors first
            for (int i = 0; i < 3; i++) begin
              e[i]  <= DW'(vb[i]) - DW'(va[i]);
              f[i]  <= DW'(vc[i]) - DW'(va[i]);
              bv[i] <= DW'(cfg[i]) - DW'(va[i]);
            end
            step <= '0;
          end else if (step == 6'd24) begin
            if (tri_hit) begin
              state <= ST_POINT;
              axis  <= '0;
              pstep <= '0;
            end else begin
              state <= ST_END;
            end
          end else begin
            acc <= acc_next;
            if (store) begin
              case (target)
                T_Q0: q[0] <= acc_next;
                T_Q1: q[1] <= acc_next;
                T_Q2: q[2] <= acc_next;
                T_D:  den  <= acc_next;
                T_U:  uu   <= acc_next;
                T_P0: p[0] <= acc_next;
                T_P1: p[1] <= acc_next;
                T_P2: p[2] <= acc_next;
                T_V:  vv   <= acc_next;
                T_W:  ww   <= acc_next;
                default: begin end
              endcase
            end
            step <= step + 1'b1;
          end
        end
        ST_POINT: begin
          acc   <= acc_next;
          pstep <= pstep + 1'b1;
          if (pstep == 2'd3) begin
            num_neg   <= acc_next < 0;
            num_mag   <= (acc_next < 0) ? MW'(-acc_next) : MW'(acc_next);
            div_start <= 1'b1;
            state     <= ST_DIVGO;
          end
        end
        ST_DIVGO: state <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            pt[axis] <= sat_val;
            if (axis == 2'd2) begin
              found <= 1'b1;
              state <= ST_END;
            end else begin
              axis  <= axis + 1'b1;
              state <= ST_POINT;
            end
          end
        end
        ST_END: state <= last ? ST_OUT : ST_IDLE;
        ST_OUT: begin
          if (hit_out.ready) begin
            found <= 1'b0;
            for (int i = 0; i < 3; i++) pt[i] <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== bench/ray_triangle_first_hit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_triangle_first_hit_tb
// Drives triangle sets under several rays, predicts each set's first hit in exact wide
// arithmetic or takes it from a directed row, and checks each hit result field by field.
// ----------------------------------------------------------------------------
module ray_triangle_first_hit_tb;

  typedef logic signed [rtfh_pkg::COORD_WIDTH-1:0] coord_t;
  typedef logic signed [127:0]           acc_t;
  typedef acc_t                          vec_t [3];

  typedef struct {
    coord_t a [3];
    coord_t b [3];
    coord_t c [3];
    logic   last_face;
  } tri_t;

  typedef struct {
    logic   hit;
    coord_t pt [3];
  } hit_t;

  typedef struct {
    tri_t t;
    bit   lit;
    hit_t want;
  } row_t;

  localparam int MAX_IDLE = 5000;
  localparam int SETTLE   = 400;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [rtfh_pkg::ADDR_WIDTH-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  rtfh_tri_if tri_if ();
  rtfh_hit_if hit_if ();

  ray_triangle_first_hit u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tri_in  (tri_if),
    .hit_out (hit_if)
  );

  coord_t ray_reg [rtfh_pkg::NUM_REGS];
  logic   set_found;
  coord_t set_point [3];
  hit_t   pending_hits [$];
  row_t   sent_rows [$];
  int     errors;
  int     results_seen;
  int     idle_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------- exact predictor ----------------
  function automatic void cross3(input vec_t x, input vec_t y, output vec_t r);
    r[0] = x[1] * y[2] - x[2] * y[1];
    r[1] = x[2] * y[0] - x[0] * y[2];
    r[2] = x[0] * y[1] - x[1] * y[0];
  endfunction

  function automatic acc_t dot3(input vec_t x, input vec_t y);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic bit trace_triangle(input tri_t t, output coord_t pt [3]);
    vec_t e, f, d, bv, q, p;
    acc_t den, u, v, w, quo;
    for (int k = 0; k < 3; k++) begin
      e[k]  = acc_t'(t.b[k]) - acc_t'(t.a[k]);
      f[k]  = acc_t'(t.c[k]) - acc_t'(t.a[k]);
      d[k]  = acc_t'(ray_reg[rtfh_pkg::REG_DIR_X + k]);
      bv[k] = acc_t'(ray_reg[k]) - acc_t'(t.a[k]);
      pt[k] = '0;
    end
    cross3(e, d, q);
    den = dot3(f, q);
    if (den <= 0) return 1'b0;
    u = dot3(bv, q);
    if (u < 0 || u > den) return 1'b0;
    cross3(f, bv, p);
    v = dot3(d, p);
    if (v < 0 || u + v > den) return 1'b0;
    w = dot3(e, p);
    if (w < 0) return 1'b0;
    for (int k = 0; k < 3; k++) begin
      quo = (acc_t'(ray_reg[k]) * den + d[k] * w) / den;
      if (quo > 32767) pt[k] = 16'sh7fff;
      else if (quo < -32768) pt[k] = 16'sh8000;
      else pt[k] = coord_t'(quo);
    end
    return 1'b1;
  endfunction

  // accepted triangle: advance set state, queue the result on the last face
  always @(posedge clk) begin
    row_t   r;
    coord_t pt [3];
    hit_t   h;
    if (!rst && tri_if.valid && tri_if.ready) begin
      r = sent_rows.pop_front();
      if (!set_found && trace_triangle(r.t, pt)) begin
        set_found = 1'b1;
        set_point = pt;
      end
      if (r.t.last_face) begin
        h.hit = set_found;
        for (int k = 0; k < 3; k++) h.pt[k] = set_found ? set_point[k] : '0;
        if (r.lit) h = r.want;
        pending_hits.insert(pending_hits.size(), h);
        set_found = 1'b0;
        for (int k = 0; k < 3; k++) set_point[k] = '0;
      end
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk) begin
    hit_t w;
    if (!rst && hit_if.valid && hit_if.ready) begin
      results_seen++;
      if (pending_hits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0b", hit_if.hit);
      end else begin
        w = pending_hits.pop_front();
        if (w.hit !== hit_if.hit || w.pt[0] !== hit_if.hit_x ||
            w.pt[1] !== hit_if.hit_y || w.pt[2] !== hit_if.hit_z) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected hit=%0b (%0d,%0d,%0d) got hit=%0b (%0d,%0d,%0d)",
                     w.hit, w.pt[0], w.pt[1], w.pt[2], hit_if.hit,
                     hit_if.hit_x, hit_if.hit_y, hit_if.hit_z);
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else if ((tri_if.valid && tri_if.ready) || (hit_if.valid && hit_if.ready) ||
             (psel && penable && pwrite && pready)) idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= MAX_IDLE) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------- receiver ----------------
  initial begin
    int hold_left;
    int calm_left;
    int r;
    bit long_done;
    hit_if.ready = 1'b0;
    hold_left = 0;
    calm_left = 0;
    long_done = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (hold_left > 0) begin
        hold_left--;
        hit_if.ready = 1'b0;
      end else if (!long_done && results_seen >= 8) begin
        // long hold so the block backs up and stalls the triangle side
        long_done = 1'b1;
        hold_left = 800;
        hit_if.ready = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        hit_if.ready = 1'b1;
      end else if (r < 5) begin
        calm_left = $urandom_range(50, 300);
        hit_if.ready = 1'b1;
      end else if (r < 60) begin
        hit_if.ready = 1'b1;
      end else begin
        hit_if.ready = 1'b0;
        hold_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic coord_t clamp16(input int x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return coord_t'(x);
  endfunction

  function automatic tri_t noise_tri();
    tri_t t;
    for (int k = 0; k < 3; k++) begin
      t.a[k] = coord_t'($urandom);
      t.b[k] = coord_t'($urandom);
      t.c[k] = coord_t'($urandom);
    end
    t.last_face = 1'b0;
    return t;
  endfunction

  // triangle whose centroid lies on the ray, random winding and size
  function automatic tri_t aimed_tri();
    tri_t t;
    int ctr, u1, u2, rad, tq;
    tq  = $urandom_range(0, 8);
    rad = ($urandom_range(0, 9) == 0) ? $urandom_range(2000, 16000)
                                      : $urandom_range(1, 1500);
    for (int k = 0; k < 3; k++) begin
      ctr = int'(ray_reg[k]) + (int'(ray_reg[rtfh_pkg::REG_DIR_X + k]) * tq) / 4;
      u1 = $urandom_range(0, 2 * rad) - rad;
      u2 = $urandom_range(0, 2 * rad) - rad;
      t.a[k] = clamp16(ctr + u1);
      t.b[k] = clamp16(ctr + u2);
      t.c[k] = clamp16(ctr - u1 - u2);
    end
    t.last_face = 1'b0;
    return t;
  endfunction

  task automatic reg_write(input int idx, input coord_t val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = rtfh_pkg::ADDR_WIDTH'(4 * idx);
    pwdata  = {16'($urandom), val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < rtfh_pkg::NUM_REGS) ray_reg[idx] = val;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic settle();
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic load_ray(input coord_t s [3], input coord_t d [3]);
    settle();
    for (int k = 0; k < 3; k++) begin
      reg_write(k, s[k]);
      reg_write(rtfh_pkg::REG_DIR_X + k, d[k]);
    end
  endtask

  task automatic send_row(input row_t r);
    int g;
    int sel;
    sel = $urandom_range(0, 99);
    g = (sel < 50) ? 0 : (sel < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (g > 0) begin
      tri_if.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    tri_if.vertex_a_x = r.t.a[0];
    tri_if.vertex_a_y = r.t.a[1];
    tri_if.vertex_a_z = r.t.a[2];
    tri_if.vertex_b_x = r.t.b[0];
    tri_if.vertex_b_y = r.t.b[1];
    tri_if.vertex_b_z = r.t.b[2];
    tri_if.vertex_c_x = r.t.c[0];
    tri_if.vertex_c_y = r.t.c[1];
    tri_if.vertex_c_z = r.t.c[2];
    tri_if.last_face  = r.t.last_face;
    tri_if.valid      = 1'b1;
    sent_rows.insert(sent_rows.size(), r);
    do @(posedge clk); while (!(tri_if.valid && tri_if.ready));
    @(negedge clk);
    // drop valid so the accepted request is not offered again
    tri_if.valid = 1'b0;
  endtask

  task automatic random_sets(input int n_items);
    row_t r;
    int   len;
    int   sent;
    sent = 0;
    r.lit = 1'b0;
    while (sent < n_items) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        r.t = ($urandom_range(0, 4) == 0) ? noise_tri() : aimed_tri();
        r.t.last_face = (i == len - 1);
        send_row(r);
        sent++;
      end
    end
  endtask

  function automatic row_t mk_row(input coord_t a [3], input coord_t b [3], input coord_t c [3],
                                   input logic last, input bit lit, input logic hit);
    row_t r;
    r.t.a = a;
    r.t.b = b;
    r.t.c = c;
    r.t.last_face = last;
    r.lit = lit;
    r.want.hit = hit;
    for (int k = 0; k < 3; k++) r.want.pt[k] = '0;
    return r;
  endfunction

  initial begin
    row_t   dir_rows [$];
    coord_t s [3], d [3];
    coord_t ha [3], hb [3], hc [3], z3 [3], mx [3], mn [3], ma [3], mb [3], mc [3];
    coord_t ba [3], bb [3], bc [3];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tri_if.valid = 1'b0;
    tri_if.vertex_a_x = '0;
    tri_if.vertex_a_y = '0;
    tri_if.vertex_a_z = '0;
    tri_if.vertex_b_x = '0;
    tri_if.vertex_b_y = '0;
    tri_if.vertex_b_z = '0;
    tri_if.vertex_c_x = '0;
    tri_if.vertex_c_y = '0;
    tri_if.vertex_c_z = '0;
    tri_if.last_face = 1'b0;
    errors = 0;
    results_seen = 0;
    set_found = 1'b0;
    for (int k = 0; k < rtfh_pkg::NUM_REGS; k++) ray_reg[k] = '0;
    for (int k = 0; k < 3; k++) set_point[k] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // registers still zero after reset: zero direction never hits
    ha = '{-256, -256, 0};
    hb = '{-256, 256, 0};
    hc = '{256, -256, 0};
    dir_rows.insert(dir_rows.size(), mk_row(ha, hb, hc, 1'b1, 1'b1, 1'b0));
    foreach (dir_rows[i]) send_row(dir_rows[i]);
    dir_rows.delete();

    // ray along +z from z=-1.0; the hit triangle is met at the origin
    s = '{0, 0, -256};
    d = '{0, 0, 256};
    load_ray(s, d);
    // writes past the last register must leave the ray alone
    reg_write(6, 16'sh1234);
    reg_write(7, 16'sh8000);

    z3 = '{0, 0, 0};
    mx = '{32767, 32767, 32767};
    mn = '{-32768, -32768, -32768};
    ma = '{-32768, 32767, -32768};
    mb = '{32767, -32768, 32767};
    mc = '{-32768, -32768, 32767};
    ba = '{-32768, -32768, 512};
    bb = '{-32768, 32767, 512};
    bc = '{32767, -32768, 512};
    dir_rows.insert(dir_rows.size(), mk_row(ha, hb, hc, 1'b1, 1'b1, 1'b1));
    dir_rows.insert(dir_rows.size(), mk_row(ha, hc, hb, 1'b1, 1'b1, 1'b0));  // back face
    dir_rows.insert(dir_rows.size(), mk_row(z3, z3, z3, 1'b1, 1'b1, 1'b0));  // degenerate
    dir_rows.insert(dir_rows.size(), mk_row(mx, mx, mx, 1'b1, 1'b1, 1'b0));
    dir_rows.insert(dir_rows.size(), mk_row(mn, mn, mn, 1'b1, 1'b1, 1'b0));
    // first hit stands; later faces of the set are skipped
    dir_rows.insert(dir_rows.size(), mk_row(ha, hc, hb, 1'b0, 1'b0, 1'b0));
    dir_rows.insert(dir_rows.size(), mk_row(ha, hb, hc, 1'b0, 1'b0, 1'b0));
    dir_rows.insert(dir_rows.size(), mk_row(ba, bb, bc, 1'b0, 1'b0, 1'b0));
    dir_rows.insert(dir_rows.size(), mk_row(ha, hc, hb, 1'b1, 1'b1, 1'b1));
    dir_rows.insert(dir_rows.size(), mk_row(ma, mb, mc, 1'b1, 1'b0, 1'b0));
    dir_rows.insert(dir_rows.size(), mk_row(mc, mb, ma, 1'b1, 1'b0, 1'b0));
    dir_rows.insert(dir_rows.size(), mk_row(ba, bb, bc, 1'b1, 1'b0, 1'b0));
    dir_rows.insert(dir_rows.size(), mk_row(ba, bc, bb, 1'b0, 1'b0, 1'b0));
    dir_rows.insert(dir_rows.size(), mk_row(ma, mx, mn, 1'b0, 1'b0, 1'b0));
    dir_rows.insert(dir_rows.size(), mk_row(ba, bb, bc, 1'b1, 1'b0, 1'b0));
    foreach (dir_rows[i]) send_row(dir_rows[i]);

    random_sets(150);

    for (int ph = 0; ph < 3; ph++) begin
      for (int k = 0; k < 3; k++) begin
        s[k] = coord_t'($urandom_range(0, 16000) - 8000);
        d[k] = coord_t'($urandom_range(0, 4000) - 2000);
      end
      load_ray(s, d);
      random_sets(100);
    end

    // extreme ray
    s = '{-32768, 32767, -32768};
    d = '{32767, -32768, 32767};
    load_ray(s, d);
    random_sets(50);

    // zero direction: every set misses
    s = '{32767, -32768, 100};
    d = '{0, 0, 0};
    load_ray(s, d);
    random_sets(30);

    // full-range random ray
    for (int k = 0; k < 3; k++) begin
      s[k] = coord_t'($urandom);
      d[k] = coord_t'($urandom);
    end
    load_ray(s, d);
    random_sets(40);

    tri_if.valid = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== ray_triangle_first_hit.f =====
sv/rtfh_pkg.sv
sv/rtfh_if.sv
sv/rtfh_div.sv
sv/ray_triangle_first_hit.sv
bench/ray_triangle_first_hit_tb.sv
